// ===== hdl/pfa_pkg.sv =====
package pfa_pkg;

    localparam int unsigned PAGES       = 128;
    localparam int unsigned FRAMES      = 32;
    localparam int unsigned PAGE_W      = $clog2(PAGES);
    localparam int unsigned FRAME_W     = $clog2(FRAMES);
    localparam int unsigned COUNT_W     = $clog2(FRAMES + 1);
    localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(FRAMES);

    typedef struct packed {
        logic [PAGE_W-1:0]  page_number;
        logic [FRAME_W-1:0] victim_choice;
    } t_in_item;

    typedef struct packed {
        logic               hit;
        logic [FRAME_W-1:0] frame_index;
        logic               evicted;
        logic [PAGE_W-1:0]  evicted_page;
        logic               bad_victim;
    } t_out_item;

    // page map write, also used for read-after-write forwarding
    typedef struct packed {
        logic               en;
        logic [PAGE_W-1:0]  addr;
        logic [FRAME_W-1:0] frame;
    } t_map_wr;

    // zero acts as one, anything above the frame total acts as the total
    function automatic logic [COUNT_W-1:0] clamp_count(input logic [COUNT_W-1:0] v);
        logic [COUNT_W-1:0] r;
        r = v;
        if (v == '0) begin
            r = COUNT_W'(1);
        end else if (v > COUNT_RESET) begin
            r = COUNT_RESET;
        end
        return r;
    endfunction

endpackage

// ===== hdl/page_fault_frame_allocator.sv =====
// Demand-paging frame allocator. Each input transfer names a virtual page and
// a victim frame. A resident page hits and returns its frame. A fault takes
// the next free frame (frame_count-1 first, down to 0); once none is free the
// victim frame's current page is unmapped and reported in evicted_page, and
// the frame goes to the new page. A victim at or above frame_count when no
// frame is free sets bad_victim and changes nothing. Writing frame_count
// (0 acts as 1, above 32 acts as 32) empties the map as reset does; write it
// only while no transfer is in flight. Rate: one item per cycle sustained
// while the result side does not stall. The result passes through the
// stage 1 register and then the output register: the page map read is a
// registered memory read in the accept cycle, and the decision and all
// table updates happen as stage 1 moves on. Only a stalled result holds up the input.
module page_fault_frame_allocator (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration: frame_count
    input  logic                            i_cfg_we,
    input  logic [pfa_pkg::COUNT_W-1:0]     i_cfg_wdata,
    // input channel
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  pfa_pkg::t_in_item               i_in_data,
    // result channel
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output pfa_pkg::t_out_item              o_out_data
);

    logic                        in_xfer;
    logic                        s1_go;
    logic                        r_s1_valid;
    pfa_pkg::t_in_item           r_s1_item;
    logic                        r_fwd_hit;
    logic [pfa_pkg::FRAME_W-1:0] r_fwd_frame;
    logic [pfa_pkg::FRAME_W-1:0] ram_frame;
    logic [pfa_pkg::FRAME_W-1:0] map_frame;
    pfa_pkg::t_map_wr            map_wr;
    pfa_pkg::t_out_item          s1_result;
    logic                        r_out_valid;
    pfa_pkg::t_out_item          r_out_data;

    // stage 1 moves when the output register is empty or being drained
    assign s1_go      = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_s1_valid && !s1_go;
    assign in_xfer    = i_in_valid && !o_in_stall;

    pfa_map_ram u_map (
        .i_clk   (i_clk),
        .i_wr    (map_wr),
        .i_re    (in_xfer),
        .i_raddr (i_in_data.page_number),
        .o_rdata (ram_frame)
    );

    // The item in stage 1 may write the same page in the cycle the next item
    // reads it; the RAM then returns old data, so capture the new frame.
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1_item   <= i_in_data;
            r_fwd_hit   <= map_wr.en && (map_wr.addr == i_in_data.page_number);
            r_fwd_frame <= map_wr.frame;
        end
    end

    assign map_frame = r_fwd_hit ? r_fwd_frame : ram_frame;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_xfer) begin
            r_s1_valid <= 1'b1;
        end else if (s1_go) begin
            r_s1_valid <= 1'b0;
        end
    end

    pfa_alloc u_alloc (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_go        (s1_go),
        .i_item      (r_s1_item),
        .i_map_frame (map_frame),
        .o_result    (s1_result),
        .o_map_wr    (map_wr)
    );

    // output register decouples the result side from the input side
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_go) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go) begin
            r_out_data <= s1_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// ===== hdl/pfa_map_ram.sv =====
module pfa_map_ram (
    input  logic                            i_clk,
    input  pfa_pkg::t_map_wr                i_wr,
    input  logic                            i_re,
    input  logic [pfa_pkg::PAGE_W-1:0]      i_raddr,
    output logic [pfa_pkg::FRAME_W-1:0]     o_rdata
);

    logic [pfa_pkg::FRAME_W-1:0] mem [pfa_pkg::PAGES];
    logic [pfa_pkg::FRAME_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            mem[i_wr.addr] <= i_wr.frame;
        end
    end

    // read returns old data on a same-address write; caller forwards
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/pfa_alloc.sv =====
module pfa_alloc (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [pfa_pkg::COUNT_W-1:0]     i_cfg_wdata,
    input  logic                            i_go,
    input  pfa_pkg::t_in_item               i_item,
    input  logic [pfa_pkg::FRAME_W-1:0]     i_map_frame,
    output pfa_pkg::t_out_item              o_result,
    output pfa_pkg::t_map_wr                o_map_wr
);

    logic [pfa_pkg::COUNT_W-1:0] r_count;
    logic [pfa_pkg::COUNT_W-1:0] r_depth;
    logic [pfa_pkg::PAGES-1:0]   r_resident;
    logic [pfa_pkg::PAGES-1:0]   n_resident;
    logic [pfa_pkg::PAGE_W-1:0]  r_owner [pfa_pkg::FRAMES];

    logic [pfa_pkg::PAGE_W-1:0]  page;
    logic [pfa_pkg::FRAME_W-1:0] victim;
    logic [pfa_pkg::COUNT_W-1:0] top;
    logic [pfa_pkg::PAGE_W-1:0]  old_owner;
    logic                        is_res;
    logic                        do_pop;
    logic                        do_evict;
    logic                        is_bad;
    logic [pfa_pkg::FRAME_W-1:0] new_frame;

    assign page      = i_item.page_number;
    assign victim    = i_item.victim_choice;
    assign top       = r_depth - pfa_pkg::COUNT_W'(1);
    assign old_owner = r_owner[victim];
    assign is_res    = r_resident[page];

    always_comb begin
        do_pop    = 1'b0;
        do_evict  = 1'b0;
        is_bad    = 1'b0;
        new_frame = '0;
        if (!is_res) begin
            if (r_depth != '0) begin
                // free stack entry i always holds i: top of stack is depth-1
                do_pop    = 1'b1;
                new_frame = top[pfa_pkg::FRAME_W-1:0];
            end else if ({1'b0, victim} >= r_count) begin
                is_bad = 1'b1;
            end else begin
                do_evict  = 1'b1;
                new_frame = victim;
            end
        end
    end

    always_comb begin
        o_result              = '0;
        o_result.hit          = is_res;
        o_result.frame_index  = is_res ? i_map_frame : new_frame;
        o_result.evicted      = do_evict;
        o_result.evicted_page = do_evict ? old_owner : '0;
        o_result.bad_victim   = is_bad;
    end

    always_comb begin
        o_map_wr       = '0;
        o_map_wr.en    = i_go && (do_pop || do_evict);
        o_map_wr.addr  = page;
        o_map_wr.frame = new_frame;
    end

    // the owner is resident and this page is not, so they differ
    always_comb begin
        n_resident = r_resident;
        if (do_evict) begin
            n_resident[old_owner] = 1'b0;
        end
        if (do_pop || do_evict) begin
            n_resident[page] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= pfa_pkg::COUNT_RESET;
            r_depth    <= pfa_pkg::COUNT_RESET;
            r_resident <= '0;
        end else if (i_cfg_we) begin
            r_count    <= pfa_pkg::clamp_count(i_cfg_wdata);
            r_depth    <= pfa_pkg::clamp_count(i_cfg_wdata);
            r_resident <= '0;
        end else if (i_go) begin
            if (do_pop) begin
                r_depth <= top;
            end
            r_resident <= n_resident;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_map_wr.en) begin
            r_owner[new_frame] <= page;
        end
    end

    a_depth_le_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= r_count)
        else $error("free depth above frame count");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != '0 && r_count <= pfa_pkg::COUNT_RESET)
        else $error("frame count out of range");

    a_bad_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        is_bad |-> (r_depth == '0 && !is_res))
        else $error("bad victim flagged while a frame is free");

    a_map_sets_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_map_wr.en && !i_cfg_we) |=> r_resident[$past(page)])
        else $error("mapped page not marked resident");

    a_pop_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_go && do_pop && !i_cfg_we) |=> r_depth == $past(r_depth) - pfa_pkg::COUNT_W'(1))
        else $error("free stack pop lost");

endmodule

// ===== tb/sv/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // ------------------------------------------------------------------
    // Clock, reset and DUT ports
    // ------------------------------------------------------------------
    logic                        i_clk       = 1'b0;
    logic                        i_rst_n     = 1'b0;
    logic                        i_cfg_we    = 1'b0;
    logic [pfa_pkg::COUNT_W-1:0] i_cfg_wdata = '0;
    logic                        i_in_valid  = 1'b0;
    logic                        o_in_stall;
    pfa_pkg::t_in_item           i_in_data   = '0;
    logic                        o_out_valid;
    logic                        i_out_stall = 1'b0;
    pfa_pkg::t_out_item          o_out_data;

    // 10 ns period
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    page_fault_frame_allocator uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    // ------------------------------------------------------------------
    // Allocator shadow: page table, frame owners, free frame stack
    // ------------------------------------------------------------------
    logic                        mapped    [pfa_pkg::PAGES];
    logic [pfa_pkg::FRAME_W-1:0] frame_of  [pfa_pkg::PAGES];
    logic [pfa_pkg::PAGE_W-1:0]  owner_of  [pfa_pkg::FRAMES];
    logic [pfa_pkg::FRAME_W-1:0] free_list [pfa_pkg::FRAMES];
    int unsigned                 free_top;
    logic [pfa_pkg::COUNT_W-1:0] frame_count_reg;

    pfa_pkg::t_out_item          pending_results [$];
    int                          fail_count = 0;

    // idle percentages for sender and receiver, changed per phase
    int                          send_idle_pct  = 0;
    int                          recv_stall_pct = 0;

    // 0 behaves as 1, anything past the frame total as the total
    function automatic int unsigned usable_frames();
        if (frame_count_reg == '0)
            return 1;
        if (frame_count_reg > pfa_pkg::COUNT_W'(pfa_pkg::FRAMES))
            return pfa_pkg::FRAMES;
        return int'(frame_count_reg);
    endfunction

    // Same effect as reset or a frame count write: nothing mapped,
    // stack holds 0..n-1 with n-1 on top.
    function automatic void clear_allocator();
        for (int p = 0; p < pfa_pkg::PAGES; p++) begin
            mapped[p]   = 1'b0;
            frame_of[p] = '0;
        end
        for (int f = 0; f < pfa_pkg::FRAMES; f++) begin
            owner_of[f]  = '0;
            free_list[f] = pfa_pkg::FRAME_W'(f);
        end
        free_top = usable_frames();
    endfunction

    // Expected result of one access; updates the shadow tables.
    function automatic pfa_pkg::t_out_item allocate_frame(input pfa_pkg::t_in_item item);
        pfa_pkg::t_out_item          res;
        logic [pfa_pkg::FRAME_W-1:0] frame;
        logic [pfa_pkg::PAGE_W-1:0]  victim_owner;
        res = '0;
        if (mapped[item.page_number]) begin
            res.hit         = 1'b1;
            res.frame_index = frame_of[item.page_number];
        end else if (free_top > 0) begin
            // fault with a free frame: pop the stack
            free_top--;
            frame                     = free_list[free_top];
            owner_of[frame]           = item.page_number;
            mapped[item.page_number]  = 1'b1;
            frame_of[item.page_number] = frame;
            res.frame_index           = frame;
        end else if (int'(item.victim_choice) >= usable_frames()) begin
            // nothing free and victim out of range: flagged, no state change
            res.bad_victim = 1'b1;
        end else begin
            // nothing free: steal the victim frame from its owner
            victim_owner               = owner_of[item.victim_choice];
            mapped[victim_owner]       = 1'b0;
            res.evicted                = 1'b1;
            res.evicted_page           = victim_owner;
            owner_of[item.victim_choice] = item.page_number;
            mapped[item.page_number]   = 1'b1;
            frame_of[item.page_number] = item.victim_choice;
            res.frame_index            = item.victim_choice;
        end
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Monitor: everything sampled at the rising edge. Pre-edge values are
    // seen here, so an accepted input transfer and an accepted result
    // transfer are both judged on what the DUT saw at this edge.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : monitor
        pfa_pkg::t_out_item want;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall)
                pending_results.push_back(allocate_frame(i_in_data));
            if (o_out_valid && !i_out_stall) begin
                if (pending_results.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: unexpected result transfer %p", $realtime, o_out_data);
                end else begin
                    want = pending_results.pop_front();
                    if (o_out_data.hit          !== want.hit          ||
                        o_out_data.frame_index  !== want.frame_index  ||
                        o_out_data.evicted      !== want.evicted      ||
                        o_out_data.evicted_page !== want.evicted_page ||
                        o_out_data.bad_victim   !== want.bad_victim) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("%0t: mismatch expected %p actual %p",
                                     $realtime, want, o_out_data);
                    end
                end
            end
        end
    end

    // Receiver back-pressure, redrawn every falling edge
    always @(negedge i_clk)
        i_out_stall <= ($urandom_range(99) < recv_stall_pct);

    // ------------------------------------------------------------------
    // Driver tasks: entered and left at a falling edge
    // ------------------------------------------------------------------

    // One input transfer. Valid goes up without looking at stall and the
    // payload holds until the transfer happens.
    task automatic send_item(input logic [pfa_pkg::PAGE_W-1:0] page,
                             input logic [pfa_pkg::FRAME_W-1:0] victim);
        pfa_pkg::t_in_item item;
        item.page_number   = page;
        item.victim_choice = victim;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        do
            @(posedge i_clk);
        while (o_in_stall);
        @(negedge i_clk);
    endtask

    // Stop sending, let every expected result arrive, then let the
    // two-stage pipe settle.
    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // Frame count write, only with the pipe empty
    task automatic write_frame_count(input logic [pfa_pkg::COUNT_W-1:0] value);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        frame_count_reg = value;
        clear_allocator();
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset count of 32: stack pops from the top, then a hit
    task automatic test_reset_count();
        send_item(pfa_pkg::PAGE_W'(0), pfa_pkg::FRAME_W'(31));
        send_item(pfa_pkg::PAGE_W'(127), pfa_pkg::FRAME_W'(0));
        send_item(pfa_pkg::PAGE_W'(0), pfa_pkg::FRAME_W'(0));
    endtask

    // Two frames: fill, then evict both ways, bad victims, victim extremes
    task automatic test_eviction();
        write_frame_count(pfa_pkg::COUNT_W'(2));
        send_item(pfa_pkg::PAGE_W'(5), pfa_pkg::FRAME_W'(0));
        send_item(pfa_pkg::PAGE_W'(6), pfa_pkg::FRAME_W'(31));
        send_item(pfa_pkg::PAGE_W'(5), pfa_pkg::FRAME_W'(31));   // hit, victim ignored
        send_item(pfa_pkg::PAGE_W'(7), pfa_pkg::FRAME_W'(0));    // evicts page 6
        send_item(pfa_pkg::PAGE_W'(8), pfa_pkg::FRAME_W'(1));    // evicts page 5
        send_item(pfa_pkg::PAGE_W'(9), pfa_pkg::FRAME_W'(31));   // victim past count
        send_item(pfa_pkg::PAGE_W'(9), pfa_pkg::FRAME_W'(2));    // victim equal to count
        send_item(pfa_pkg::PAGE_W'(7), pfa_pkg::FRAME_W'(1));    // still resident
        send_item(pfa_pkg::PAGE_W'(127), pfa_pkg::FRAME_W'(1));  // evicts page 8
        send_item(pfa_pkg::PAGE_W'(6), pfa_pkg::FRAME_W'(0));    // evicts page 7
    endtask

    // Out-of-range counts: 0 acts as 1, 63 acts as 32
    task automatic test_count_limits();
        write_frame_count(pfa_pkg::COUNT_W'(0));
        send_item(pfa_pkg::PAGE_W'(3), pfa_pkg::FRAME_W'(0));
        send_item(pfa_pkg::PAGE_W'(4), pfa_pkg::FRAME_W'(1));    // bad victim, one frame
        send_item(pfa_pkg::PAGE_W'(4), pfa_pkg::FRAME_W'(0));    // evicts page 3
        write_frame_count(pfa_pkg::COUNT_W'(63));
        send_item(pfa_pkg::PAGE_W'(100), pfa_pkg::FRAME_W'(31)); // frame 31 on top again
        send_item(pfa_pkg::PAGE_W'(1), pfa_pkg::FRAME_W'(31));
        send_item(pfa_pkg::PAGE_W'(100), pfa_pkg::FRAME_W'(5));
    endtask

    // Random traffic at one count and one idle setting. Most pages come
    // from a window about twice the frame count wide so hits, refills and
    // evictions all happen; victims mostly in range.
    task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                       input logic [pfa_pkg::COUNT_W-1:0] count,
                                       input int n);
        int unsigned                 frames;
        logic [pfa_pkg::PAGE_W-1:0]  base;
        logic [pfa_pkg::PAGE_W-1:0]  page;
        logic [pfa_pkg::FRAME_W-1:0] victim;
        write_frame_count(count);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        frames = usable_frames();
        base   = pfa_pkg::PAGE_W'($urandom_range(pfa_pkg::PAGES - 1));
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(99) < 75)
                page = base + pfa_pkg::PAGE_W'($urandom_range(2 * frames));
            else
                page = pfa_pkg::PAGE_W'($urandom_range(pfa_pkg::PAGES - 1));
            if ($urandom_range(99) < 85)
                victim = pfa_pkg::FRAME_W'($urandom_range(frames - 1));
            else
                victim = pfa_pkg::FRAME_W'($urandom_range(pfa_pkg::FRAMES - 1));
            send_item(page, victim);
        end
        send_idle_pct  = 0;
        recv_stall_pct = 0;
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin : sequencer
        logic [pfa_pkg::COUNT_W-1:0] counts [12];
        int                          idle_set  [4];
        int                          stall_set [4];
        counts    = '{6'd1, 6'd32, 6'd5, 6'd63, 6'd2, 6'd17,
                      6'd0, 6'd9, 6'd32, 6'd33, 6'd3, 6'd24};
        // no idling, sender idle, receiver stalling, both
        idle_set  = '{0, 79, 0, 26};
        stall_set = '{0, 0, 79, 26};

        frame_count_reg = pfa_pkg::COUNT_RESET;
        clear_allocator();
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(negedge i_clk);

        test_reset_count();
        test_eviction();
        test_count_limits();
        for (int ph = 0; ph < 4; ph++)
            for (int c = 0; c < 3; c++)
                test_random_traffic(idle_set[ph], stall_set[ph], counts[3 * ph + c], 100);

        drain();
        if (fail_count == 0 && pending_results.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // Hard stop, far past the slowest legal run
    initial begin : watchdog
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
